// ===== design/rrwl_pkg.sv =====
`default_nettype none

package rrwl_pkg;

    localparam int SECTORS_DEF    = 256;
    localparam int COUNT_BITS_DEF = 32;
    localparam int TOTAL_BITS     = 40;

    localparam logic [1:0] FUNC_ERASE   = 2'd0;
    localparam logic [1:0] FUNC_RESTORE = 2'd1;
    localparam logic [1:0] FUNC_QUERY   = 2'd2;

    localparam logic [2:0] FR_OK       = 3'd0;
    localparam logic [2:0] FR_TIMEOUT  = 3'd1;
    localparam logic [2:0] FR_INVALID  = 3'd2;
    localparam logic [2:0] FR_NOT_INIT = 3'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_TIMEOUT   = 3'd3;
    localparam logic [2:0] ST_FLASH_ERR = 3'd4;
    localparam logic [2:0] ST_NOT_INIT  = 3'd5;

    typedef struct packed {
        logic [2:0]            status;
        logic [7:0]            erased_sector;
        logic [7:0]            next_ptr;
        logic [31:0]           queried_count;
        logic [7:0]            successor_sector;
        logic [31:0]           min_count;
        logic [31:0]           max_count;
        logic [8:0]            sectors_at_min;
        logic [8:0]            sectors_at_max;
        logic [TOTAL_BITS-1:0] erase_total;
    } t_result;

endpackage

`default_nettype wire

// ===== design/rrwl_ifs.sv =====
`default_nettype none

interface rrwl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [9:0] sector_sel;
    logic [2:0] flash_result;

    modport source (output valid, output func, output sector_sel, output flash_result,
                    input ready);
    modport sink (input valid, input func, input sector_sel, input flash_result,
                  output ready);
endinterface

interface rrwl_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  erased_sector;
    logic [7:0]  next_ptr;
    logic [31:0] queried_count;
    logic [7:0]  successor_sector;
    logic [31:0] min_count;
    logic [31:0] max_count;
    logic [8:0]  sectors_at_min;
    logic [8:0]  sectors_at_max;
    logic [31:0] spread;
    logic [39:0] erase_total;
    logic        imbalanced;

    modport source (output valid, output status, output erased_sector, output next_ptr,
                    output queried_count, output successor_sector, output min_count,
                    output max_count, output sectors_at_min, output sectors_at_max,
                    output spread, output erase_total, output imbalanced, input ready);
    modport sink (input valid, input status, input erased_sector, input next_ptr,
                  input queried_count, input successor_sector, input min_count,
                  input max_count, input sectors_at_min, input sectors_at_max,
                  input spread, input erase_total, input imbalanced, output ready);
endinterface

interface rrwl_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/rrwl_ram.sv =====
`default_nettype none

module rrwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/rrwl_core.sv =====
`default_nettype none

module rrwl_core #(
    parameter int SECTORS    = rrwl_pkg::SECTORS_DEF,
    parameter int COUNT_BITS = rrwl_pkg::COUNT_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [1:0]       i_func,
    input  wire logic [9:0]       i_sector_sel,
    input  wire logic [2:0]       i_flash_result,
    input  wire logic             i_out_free,
    output logic                  o_done,
    output rrwl_pkg::t_result     o_result
);
    import rrwl_pkg::*;

    localparam int PW = $clog2(SECTORS);
    localparam int CW = $clog2(SECTORS + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic [TOTAL_BITS-1:0] TMAX = '1;
    localparam logic [PW-1:0] LAST = PW'(SECTORS - 1);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_RD, S_EV, S_SCAN, S_LAST, S_DONE
    } t_state;

    t_state                r_state;
    logic [1:0]            r_func;
    logic [9:0]            r_idx;
    logic [2:0]            r_fres;
    logic [PW-1:0]         r_ptr;
    logic [PW-1:0]         r_addr;
    logic                  r_sv;
    logic                  r_first;
    logic [COUNT_BITS-1:0] r_min;
    logic [COUNT_BITS-1:0] r_max;
    logic [CW-1:0]         r_nmin;
    logic [CW-1:0]         r_nmax;
    logic [TOTAL_BITS-1:0] r_total;
    logic [2:0]            r_status;
    logic [PW-1:0]         r_erased;
    logic [COUNT_BITS-1:0] r_qcount;
    logic [PW-1:0]         r_succ;

    logic                  w_we;
    logic [PW-1:0]         w_waddr;
    logic [COUNT_BITS-1:0] w_wdata;
    logic [PW-1:0]         w_raddr;
    logic [COUNT_BITS-1:0] w_rdata;
    logic [PW-1:0]         w_idx;
    logic                  w_in_range;
    logic                  w_erase_ok;

    function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] s);
        return (s == LAST) ? '0 : s + 1'b1;
    endfunction

    assign w_idx      = PW'(r_idx);
    assign w_in_range = 32'(r_idx) < 32'(SECTORS);
    assign w_erase_ok = (r_state == S_EV) && (r_func == FUNC_ERASE) && (w_rdata != CMAX)
                        && (r_fres == FR_OK);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = '0;
        if (r_state == S_CLR) begin
            w_we = 1'b1;
        end else if (w_erase_ok) begin
            w_we    = 1'b1;
            w_waddr = r_ptr;
            w_wdata = w_rdata + 1'b1;
        end
    end

    always_comb begin
        case (r_state)
            S_RD:    w_raddr = (r_func == FUNC_ERASE) ? r_ptr : w_idx;
            S_SCAN:  w_raddr = r_addr;
            default: w_raddr = r_addr;
        endcase
    end

    rrwl_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (SECTORS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr  <= '0;
            r_ptr   <= '0;
            r_sv    <= 1'b0;
            r_first <= 1'b0;
            r_min   <= '0;
            r_max   <= '0;
            r_nmin  <= CW'(SECTORS);
            r_nmax  <= CW'(SECTORS);
            r_total <= '0;
        end else begin
            r_sv <= 1'b0;
            // statistics from the scan, one read behind the address
            if (r_sv) begin
                if (r_first) begin
                    r_min  <= w_rdata;
                    r_max  <= w_rdata;
                    r_nmin <= CW'(1);
                    r_nmax <= CW'(1);
                end else begin
                    if (w_rdata < r_min) begin
                        r_min  <= w_rdata;
                        r_nmin <= CW'(1);
                    end else if (w_rdata == r_min) begin
                        r_nmin <= r_nmin + 1'b1;
                    end
                    if (w_rdata > r_max) begin
                        r_max  <= w_rdata;
                        r_nmax <= CW'(1);
                    end else if (w_rdata == r_max) begin
                        r_nmax <= r_nmax + 1'b1;
                    end
                end
            end
            case (r_state)
                S_CLR: begin
                    if (r_addr == LAST) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_func   <= i_func;
                        r_idx    <= i_sector_sel;
                        r_fres   <= i_flash_result;
                        r_status <= ST_OK;
                        r_erased <= '0;
                        r_qcount <= '0;
                        r_succ   <= '0;
                        r_state  <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    r_state <= S_DONE;
                    case (r_func)
                        FUNC_ERASE: begin
                            if (w_rdata == CMAX) begin
                                r_status <= ST_OVERFLOW;
                            end else begin
                                case (r_fres)
                                    FR_OK: begin
                                        if (r_total != TMAX) begin
                                            r_total <= r_total + 1'b1;
                                        end
                                        r_erased <= r_ptr;
                                        r_ptr    <= wrap_next(r_ptr);
                                        r_addr   <= '0;
                                        r_state  <= S_SCAN;
                                    end
                                    FR_TIMEOUT:  r_status <= ST_TIMEOUT;
                                    FR_INVALID:  r_status <= ST_INVALID;
                                    FR_NOT_INIT: r_status <= ST_NOT_INIT;
                                    default:     r_status <= ST_FLASH_ERR;
                                endcase
                            end
                        end
                        FUNC_RESTORE: begin
                            if (w_in_range) begin
                                r_ptr <= w_idx;
                            end else begin
                                r_status <= ST_INVALID;
                            end
                        end
                        FUNC_QUERY: begin
                            if (w_in_range) begin
                                r_qcount <= w_rdata;
                                r_succ   <= wrap_next(w_idx);
                            end else begin
                                r_status <= ST_INVALID;
                            end
                        end
                        default: r_status <= ST_INVALID;
                    endcase
                end
                S_SCAN: begin
                    r_sv    <= 1'b1;
                    r_first <= (r_addr == '0);
                    if (r_addr == LAST) begin
                        r_state <= S_LAST;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_LAST: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE) && i_out_free;

    always_comb begin
        o_result.status           = r_status;
        o_result.erased_sector    = 8'(r_erased);
        o_result.next_ptr         = 8'(r_ptr);
        o_result.queried_count    = 32'(r_qcount);
        o_result.successor_sector = 8'(r_succ);
        o_result.min_count        = 32'(r_min);
        o_result.max_count        = 32'(r_max);
        o_result.sectors_at_min   = 9'(r_nmin);
        o_result.sectors_at_max   = 9'(r_nmax);
        o_result.erase_total      = r_total;
    end

endmodule

`default_nettype wire

// ===== design/round_robin_wear_leveler.sv =====
// path: restore, count query and an erase report that is refused go from input transfer
// through S_RD and S_EV to S_DONE and the result register; an ok erase report also passes
// through the one-read-per-cycle rescan of the store (S_SCAN, S_LAST) before S_DONE
// one item at a time; the next input is taken as soon as a result sits in the output register
// reset: the counter store is cleared by a pass over all SECTORS entries, input not ready meanwhile;
// the spread limit resets to zero and configuration writes are taken at any time
`default_nettype none

module round_robin_wear_leveler #(
    parameter int SECTORS    = rrwl_pkg::SECTORS_DEF,
    parameter int COUNT_BITS = rrwl_pkg::COUNT_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rrwl_in_if.sink   i_in,
    rrwl_out_if.source o_out,
    rrwl_cfg_if.sink  i_cfg
);
    import rrwl_pkg::*;

    logic [31:0] r_spread_limit;
    logic        r_out_valid;
    t_result     r_out;
    logic [31:0] r_spread;
    logic        r_imb;

    logic        w_out_free;
    logic        w_done;
    t_result     w_res;
    logic [31:0] w_spread;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_spread   = w_res.max_count - w_res.min_count;

    rrwl_core #(
        .SECTORS    (SECTORS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in.valid),
        .o_ready        (i_in.ready),
        .i_func         (i_in.func),
        .i_sector_sel   (i_in.sector_sel),
        .i_flash_result (i_in.flash_result),
        .i_out_free     (w_out_free),
        .o_done         (w_done),
        .o_result       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spread_limit <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_spread_limit <= i_cfg.data;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_done) begin
            r_out    <= w_res;
            r_spread <= w_spread;
            r_imb    <= w_spread > r_spread_limit;
        end
    end

    assign i_cfg.ready = 1'b1;

    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_out.status;
    assign o_out.erased_sector    = r_out.erased_sector;
    assign o_out.next_ptr         = r_out.next_ptr;
    assign o_out.queried_count    = r_out.queried_count;
    assign o_out.successor_sector = r_out.successor_sector;
    assign o_out.min_count        = r_out.min_count;
    assign o_out.max_count        = r_out.max_count;
    assign o_out.sectors_at_min   = r_out.sectors_at_min;
    assign o_out.sectors_at_max   = r_out.sectors_at_max;
    assign o_out.spread           = r_spread;
    assign o_out.erase_total      = r_out.erase_total;
    assign o_out.imbalanced       = r_imb;

endmodule

`default_nettype wire
